### hw/rtl/sobel_edge_magnitude_assert.svh
// Assertion macros for the Sobel edge magnitude block.
// Used by the top level; no other dependencies.
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// Implication check, disabled during reset.
`define SEM_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication check, disabled during reset.
`define SEM_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

### hw/rtl/sem_pkg.sv
// Package for the Sobel edge magnitude block: sizes, register indexes, types.
// No dependencies.
package sem_pkg;

  localparam int MaxWidth    = 2048;
  localparam int MaxChannels = 4;
  localparam int LineDepth   = MaxWidth * MaxChannels;
  localparam int AddrW       = $clog2(LineDepth);
  localparam int QDepth      = 4;

  localparam logic [1:0] RegWidth    = 2'd0;
  localparam logic [1:0] RegHeight   = 2'd1;
  localparam logic [1:0] RegChannels = 2'd2;

  // One window job from front to back: 3x3 pixels plus tags.
  typedef struct packed {
    logic [8:0][7:0] pix;   // t0 t1 t2 m0 m1 m2 b0 b1 b2, index 0 = t0
    logic [15:0]     row;
    logic [10:0]     col;
    logic [1:0]      chan;
    logic            run_last;
    logic            frame_last;
  } job_t;

  // Result item.
  typedef struct packed {
    logic [7:0]  edge_value;
    logic [15:0] row;
    logic [10:0] col;
    logic [1:0]  chan;
    logic        run_last;
    logic        frame_last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EMIT  = 3'b100
  } front_state_t;

endpackage

### hw/rtl/sobel_edge_magnitude.sv
// Sobel edge magnitude, 3x3, streaming; top level.
// Channels: s_axis takes one 8-bit sample per transaction in raster order with
// channels interleaved. m_axis gives one result per transaction.
// cfg is a write channel (index, data): 0 width, 1 height, 2 channel count.
// Write it only while the block is idle.
// A sample passes the front part through accept, line memory read and
// release, and no new sample is taken until the queue has its results. Each
// result then passes the back part through gradients, squares, eight root
// bits and hand-off, the root set to 255 at once when the magnitude saturates;
// a four-entry queue parts the two. A result for pixel (R, X) leaves after the
// sample of (R+1, X+1), one in the last column after (R+1, X), one in the last
// row after (R, X+1) and the last pixel of an image after its own sample.
// Reset clears counters and windows; line memories are not cleared, and stale
// entries read in the first two rows of an image are never used.
// When m_axis stalls the queue fills and s_axis_tready falls.
// Depends on sem_pkg, sem_front, sem_queue, sem_back, sem_ram (via sem_front).
`include "sobel_edge_magnitude_assert.svh"
module sobel_edge_magnitude
  import sem_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] edge_value, [23:8] out_row,
                                      // [34:24] out_col, [36:35] out_channel
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser,   // frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [11:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  channel_count;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 12'd640; image_height <= 16'd480; channel_count <= 3'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegWidth:    image_width <= cfg_data[11:0];
        RegHeight:   image_height <= cfg_data;
        RegChannels: channel_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;
  res_t res;

  sem_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_sample(s_axis_tdata), .image_width(image_width), .image_height(image_height),
    .channel_count(channel_count), .job_valid(fj_valid), .job_ready(fj_ready), .job(fj));

  sem_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
    .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj));

  sem_back u_back (
    .clk(clk), .rst(rst), .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res));

  assign m_axis_tdata = {3'd0, res.chan, res.col, res.row, res.edge_value};
  assign m_axis_tlast = res.run_last;
  assign m_axis_tuser = res.frame_last;

  // A frame end is always the last result of its sample.
  `SEM_ASSERT_IMP(a_frame_run, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  // A stalled result holds its payload.
  `SEM_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  // The front part takes no sample while it is releasing results.
  `SEM_ASSERT_IMP(a_front_excl, clk, rst, fj_valid, !s_axis_tready)

endmodule

### hw/rtl/sem_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sem_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sem_front.sv
// Front part: takes samples, keeps line memories and windows, builds window jobs.
// Depends on sem_pkg and sem_ram.
module sem_front
  import sem_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_sample,
  input  logic [11:0] image_width,
  input  logic [15:0] image_height,
  input  logic [2:0]  channel_count,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  front_state_t state;
  logic [15:0] row_counter;
  logic [10:0] col_counter;
  logic [1:0]  chan_counter;
  logic [7:0]  s_hold;
  logic [7:0]  recent [2*MaxChannels];
  logic [7:0]  win_above [2*MaxChannels];
  logic [7:0]  win_two [2*MaxChannels];
  logic [7:0]  an, tn;
  logic [3:0]  want_q;

  // Clamped configuration.
  logic [11:0] w_eff;
  logic [15:0] h_eff;
  logic [2:0]  nc_eff;
  logic [15:0] r;
  logic [10:0] c;
  logic [1:0]  ch;
  logic [AddrW-1:0] idx;
  logic has_left, row_end, last_row, ch_last;

  always_comb begin
    w_eff  = (image_width == 12'd0) ? 12'd1 :
             (image_width > 12'(MaxWidth) ? 12'(MaxWidth) : image_width);
    h_eff  = (image_height == 16'd0) ? 16'd1 : image_height;
    nc_eff = (channel_count == 3'd0) ? 3'd1 :
             (channel_count > 3'(MaxChannels) ? 3'(MaxChannels) : channel_count);
    r  = (row_counter >= h_eff) ? h_eff - 16'd1 : row_counter;
    c  = ({1'b0, col_counter} >= w_eff) ? 11'(w_eff - 12'd1) : col_counter;
    ch = ({1'b0, chan_counter} >= nc_eff) ? 2'(nc_eff - 3'd1) : chan_counter;
    idx = AddrW'({c, ch});
    has_left = (c != 11'd0);
    row_end  = ({1'b0, c} == w_eff - 12'd1);
    last_row = (r == h_eff - 16'd1);
    ch_last  = ({1'b0, ch} == nc_eff - 3'd1);
  end

  // Window slots of the current channel: newer column low, older column high.
  logic [2:0] lo_i, hi_i;
  assign lo_i = {1'b0, ch};
  assign hi_i = 3'(MaxChannels) + lo_i;

  // Line memories: read on accept, write back after fetch.
  logic wr_en;
  logic [7:0] an_rd, tn_rd;
  assign wr_en = (state == S_FETCH);

  sem_ram #(.Width(8), .Depth(LineDepth)) u_above (
    .clk(clk), .we(wr_en), .waddr(idx), .wdata(s_hold), .raddr(idx), .rdata(an_rd));
  sem_ram #(.Width(8), .Depth(LineDepth)) u_two (
    .clk(clk), .we(wr_en), .waddr(idx), .wdata(an_rd), .raddr(idx), .rdata(tn_rd));

  assign in_ready = (state == S_IDLE);

  // Windows for the current channel.
  logic [7:0] tw [3], aw [3], cw [3];
  always_comb begin
    tw[0] = win_two[hi_i]; tw[1] = win_two[lo_i]; tw[2] = tn;
    aw[0] = win_above[hi_i]; aw[1] = win_above[lo_i]; aw[2] = an;
    cw[0] = recent[hi_i]; cw[1] = recent[lo_i]; cw[2] = s_hold;
  end

  // Current job slot: bit0 pass0 body, bit1 pass0 tail, bit2 pass1 body, bit3 pass1 tail.
  logic [1:0] slot;
  logic       tail, pass1;
  logic [3:0] remain_after;
  always_comb begin
    slot = 2'd0;
    if (want_q[0]) slot = 2'd0;
    else if (want_q[1]) slot = 2'd1;
    else if (want_q[2]) slot = 2'd2;
    else slot = 2'd3;
    tail  = slot[0];
    pass1 = slot[1];
    remain_after = want_q & ~(4'b0001 << slot);
  end

  function automatic logic [2:0][7:0] pick_f(input logic [7:0] a0, input logic [7:0] a1,
                                             input logic [7:0] a2, input logic t,
                                             input logic hl);
    logic [2:0][7:0] o;
    if (!t) begin
      o[0] = a0; o[1] = a1; o[2] = a2;
    end else begin
      o[0] = hl ? a1 : a2; o[1] = a2; o[2] = a2;
    end
    return o;
  endfunction

  logic [2:0][7:0] pt, pm, pb;
  always_comb begin
    if (!pass1) begin
      pt = (r >= 16'd2) ? pick_f(tw[0], tw[1], tw[2], tail, has_left)
                        : pick_f(aw[0], aw[1], aw[2], tail, has_left);
      pm = pick_f(aw[0], aw[1], aw[2], tail, has_left);
    end else begin
      pt = (r >= 16'd1) ? pick_f(aw[0], aw[1], aw[2], tail, has_left)
                        : pick_f(cw[0], cw[1], cw[2], tail, has_left);
      pm = pick_f(cw[0], cw[1], cw[2], tail, has_left);
    end
    pb = pick_f(cw[0], cw[1], cw[2], tail, has_left);
    job.pix = {pb[2], pb[1], pb[0], pm[2], pm[1], pm[0], pt[2], pt[1], pt[0]};
    job.row = pass1 ? r : r - 16'd1;
    job.col = tail ? c : c - 11'd1;
    job.chan = ch;
    job.run_last = (remain_after == 4'd0);
    job.frame_last = (remain_after == 4'd0) && last_row && row_end && ch_last;
  end

  assign job_valid = (state == S_EMIT) && (want_q != 4'd0);

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row_counter <= '0; col_counter <= '0; chan_counter <= '0;
      want_q <= '0;
      for (int i = 0; i < 2*MaxChannels; i++) begin
        recent[i] <= '0; win_above[i] <= '0; win_two[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            s_hold <= in_sample;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          an <= an_rd;
          tn <= tn_rd;
          want_q <= {last_row & row_end, last_row & has_left,
                     (r >= 16'd1) & row_end, (r >= 16'd1) & has_left};
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (want_q == 4'd0 || (job_ready && remain_after == 4'd0)) begin
            want_q <= '0;
            state <= S_IDLE;
            // Shift windows.
            if (c == 11'd0) begin
              win_two[hi_i] <= tn; win_two[lo_i] <= tn;
              win_above[hi_i] <= an; win_above[lo_i] <= an;
              recent[hi_i] <= s_hold; recent[lo_i] <= s_hold;
            end else begin
              win_two[hi_i] <= win_two[lo_i]; win_two[lo_i] <= tn;
              win_above[hi_i] <= win_above[lo_i]; win_above[lo_i] <= an;
              recent[hi_i] <= recent[lo_i]; recent[lo_i] <= s_hold;
            end
            if (ch_last) begin
              chan_counter <= '0;
              if (row_end) begin
                col_counter <= '0;
                row_counter <= last_row ? 16'd0 : r + 16'd1;
              end else begin
                col_counter <= c + 11'd1;
                row_counter <= r;
              end
            end else begin
              chan_counter <= ch + 2'd1;
              col_counter <= c;
              row_counter <= r;
            end
          end else if (job_ready) begin
            want_q <= remain_after;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/sem_queue.sv
// Short job queue between front and back parts.
// Depends on sem_pkg.
module sem_queue
  import sem_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);

  localparam int PtrW = $clog2(QDepth);
  job_t slots [QDepth];
  logic [PtrW-1:0] wp, rp;
  logic [PtrW:0]   cnt;
  logic push, pop;

  assign in_ready  = (cnt != (PtrW+1)'(QDepth));
  assign out_valid = (cnt != '0);
  assign out_job   = slots[rp];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  // Ring pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slots[wp] <= in_job;
  end

endmodule

### hw/rtl/sem_back.sv
// Back part: Sobel gradients, squared magnitude and bit-serial integer root.
// Depends on sem_pkg.
module sem_back
  import sem_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic        busy;
  job_t        cur;
  logic signed [11:0] gx, gy;
  logic [20:0] sum;
  logic [7:0]  root;
  logic [3:0]  bitpos;
  logic [1:0]  phase;

  assign job_ready = !busy;

  // Gradients from the held window.
  logic signed [11:0] t0, t1, t2, m0, m2, b0, b1, b2;
  always_comb begin
    t0 = 12'(cur.pix[0]); t1 = 12'(cur.pix[1]); t2 = 12'(cur.pix[2]);
    m0 = 12'(cur.pix[3]); m2 = 12'(cur.pix[5]);
    b0 = 12'(cur.pix[6]); b1 = 12'(cur.pix[7]); b2 = 12'(cur.pix[8]);
  end

  logic [7:0] trial;
  logic [15:0] trial_sq;
  assign trial = root | (8'd1 << bitpos[2:0]);
  assign trial_sq = trial * trial;

  // Sequencer: phase 0 gradients, 1 squares, 2 root bits, 3 result wait.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; res_valid <= 1'b0; phase <= '0;
    end else if (!busy) begin
      if (job_valid) begin
        cur <= job; busy <= 1'b1; phase <= 2'd0;
      end
    end else begin
      case (phase)
        2'd0: begin
          gx <= (t2 - t0) + ((m2 - m0) <<< 1) + (b2 - b0);
          gy <= (b0 + (b1 <<< 1) + b2) - (t0 + (t1 <<< 1) + t2);
          phase <= 2'd1;
        end
        2'd1: begin
          sum <= 21'(gx * gx) + 21'(gy * gy);
          root <= '0; bitpos <= 4'd7;
          phase <= 2'd2;
        end
        2'd2: begin
          if (sum[20:16] != 5'd0) begin
            root <= 8'd255; phase <= 2'd3; res_valid <= 1'b1;
          end else begin
            if (trial_sq <= sum[15:0]) root <= trial;
            if (bitpos == 4'd0) begin
              phase <= 2'd3; res_valid <= 1'b1;
            end
            bitpos <= bitpos - 4'd1;
          end
        end
        default: begin
          if (res_ready) begin
            res_valid <= 1'b0; busy <= 1'b0;
          end
        end
      endcase
    end
  end

  assign res.edge_value = root;
  assign res.row = cur.row;
  assign res.col = cur.col;
  assign res.chan = cur.chan;
  assign res.run_last = cur.run_last;
  assign res.frame_last = cur.frame_last;

endmodule
